// ===== sv/bfdh_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdh_pkg
// shared constants for the double-hashing bloom filter: sizes, register
// map, request action codes and register reset values
// ----------------------------------------------------------------------------
package bfdh_pkg;

	localparam int LOG2_MAX_BITS_DEF = 16;
	localparam int MAX_PROBES_DEF    = 32;
	localparam int MIN_LOG2_BITS     = 6;

	localparam int WORD_BITS     = 64;
	localparam int WORD_SEL_BITS = 6;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic REG_LOG2_BITS   = 1'b0;
	localparam logic REG_PROBE_COUNT = 1'b1;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [4:0] LOG2_BITS_RST   = 5'd16;
	localparam logic [5:0] PROBE_COUNT_RST = 6'd7;

	localparam int OUT_TDATA_W = 40;

endpackage

// ===== sv/bloom_filter_double_hash.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// a request runs k probes (k = probe count); a query that meets a clear bit
// finishes after fewer probes
// one probe per cycle through the read port and the write port of the bit
// store; no new request is taken until the result of the last one is loaded
// reset: after arst_n the bit store is swept to zero, one word a cycle,
// and no request is taken until the sweep ends
// ----------------------------------------------------------------------------
module bloom_filter_double_hash
	import bfdh_pkg::*;
#(
	parameter int LOG2_MAX_BITS = LOG2_MAX_BITS_DEF,
	parameter int MAX_PROBES    = MAX_PROBES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// request: [63:0] id_lo, [127:64] id_hi
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [127:0]           s_tdata,
	// request: [0] action
	input  logic                   s_tuser,
	// result: [0] maybe_present, [32:1] inserted_count, [39:33] zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int LMB   = LOG2_MAX_BITS;
	localparam int WAW   = (LMB > WORD_SEL_BITS) ? LMB - WORD_SEL_BITS : 1;
	localparam int XW    = WAW + WORD_SEL_BITS;
	localparam int DEPTH = 1 << WAW;
	localparam int PCW   = $clog2(MAX_PROBES + 1);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;

	logic [4:0] log2_bits_q;
	logic [5:0] probe_count_q;

	logic [WAW-1:0] clr_cnt_q;

	// per-request registers
	logic           is_query_q;
	logic [LMB-1:0] pos_q;
	logic [LMB-1:0] stride_q;
	logic [LMB-1:0] mask_q;
	logic [PCW-1:0] k_q;
	logic [PCW-1:0] issue_cnt_q;
	logic           present_q;
	logic [31:0]    add_cnt_q;

	// probe in flight, data arriving from the store
	logic                     valid_s1;
	logic [WAW-1:0]           word_s1;
	logic [WORD_SEL_BITS-1:0] bit_s1;
	logic                     last_s1;

	// previous write, for a read that raced it
	logic                 last_we_q;
	logic [WAW-1:0]       last_waddr_q;
	logic [WORD_BITS-1:0] last_wdata_q;

	logic                 m_tvalid_q;
	logic                 out_present_q;
	logic [31:0]          out_count_q;

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] mem_rdata;
	logic                 mem_we;
	logic [WAW-1:0]       mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [WAW-1:0]       mem_raddr;

	logic                 s_acc;
	logic                 cfg_wr;
	logic [4:0]           eff_log2;
	logic [PCW-1:0]       eff_k;
	logic [LMB-1:0]       eff_mask;
	logic [XW-1:0]        probe_x;
	logic                 fwd;
	logic [WORD_BITS-1:0] cur_word;
	logic                 bit_hit;
	logic                 probe_fin;
	logic                 issue_en;
	logic                 run_we;
	logic                 out_load;

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign prdata = (paddr[2] == REG_PROBE_COUNT) ? {26'd0, probe_count_q}
	                                              : {27'd0, log2_bits_q};

	// clamp registers into the supported ranges
	always_comb begin
		if (log2_bits_q < 5'(MIN_LOG2_BITS)) begin
			eff_log2 = 5'(MIN_LOG2_BITS);
		end else if (log2_bits_q > 5'(LMB)) begin
			eff_log2 = 5'(LMB);
		end else begin
			eff_log2 = log2_bits_q;
		end
		if (probe_count_q == 6'd0) begin
			eff_k = PCW'(1);
		end else if ({1'b0, probe_count_q} > 7'(MAX_PROBES)) begin
			eff_k = PCW'(MAX_PROBES);
		end else begin
			eff_k = PCW'(probe_count_q);
		end
		for (int j = 0; j < LMB; j++) begin
			eff_mask[j] = (5'(j) < eff_log2);
		end
	end

	// data path of the probe that is back from the store
	always_comb begin
		fwd       = last_we_q && (last_waddr_q == word_s1);
		cur_word  = fwd ? last_wdata_q : mem_rdata;
		bit_hit   = cur_word[bit_s1];
		probe_fin = valid_s1 && (last_s1 || (is_query_q && !bit_hit));
		issue_en  = (state_q == ST_RUN) && (issue_cnt_q != k_q) && !probe_fin;
		run_we    = valid_s1 && (is_query_q == ACT_ADD);
		probe_x   = XW'(pos_q & mask_q);
		mem_raddr = probe_x[XW-1:WORD_SEL_BITS];
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = run_we;
			mem_waddr = word_s1;
			mem_wdata = cur_word | (WORD_BITS'(1) << bit_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata <= mem[mem_raddr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			is_query_q <= s_tuser;
			pos_q      <= s_tdata[LMB-1:0];
			stride_q   <= s_tdata[64 +: LMB] | LMB'(1);
			mask_q     <= eff_mask;
			k_q        <= eff_k;
		end else if (issue_en) begin
			pos_q <= pos_q + stride_q;
		end
		if (issue_en) begin
			word_s1 <= probe_x[XW-1:WORD_SEL_BITS];
			bit_s1  <= probe_x[WORD_SEL_BITS-1:0];
			last_s1 <= (PCW'(issue_cnt_q + 1'b1) == k_q);
		end
		last_waddr_q <= word_s1;
		last_wdata_q <= mem_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			log2_bits_q   <= LOG2_BITS_RST;
			probe_count_q <= PROBE_COUNT_RST;
			issue_cnt_q   <= '0;
			valid_s1      <= 1'b0;
			last_we_q     <= 1'b0;
			present_q     <= 1'b0;
			add_cnt_q     <= '0;
			m_tvalid_q    <= 1'b0;
			out_present_q <= 1'b0;
			out_count_q   <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_LOG2_BITS) begin
					log2_bits_q <= pwdata[4:0];
				end else begin
					probe_count_q <= pwdata[5:0];
				end
			end
			valid_s1  <= issue_en;
			last_we_q <= run_we && (state_q == ST_RUN);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						issue_cnt_q <= '0;
						state_q     <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (issue_en) begin
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end
					if (probe_fin) begin
						present_q <= (is_query_q == ACT_ADD) || bit_hit;
						if ((is_query_q == ACT_ADD) && (add_cnt_q != '1)) begin
							add_cnt_q <= add_cnt_q + 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_present_q <= present_q;
						out_count_q   <= add_cnt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_count_q, out_present_q};

	// a query never writes the store
	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && is_query_q == ACT_QUERY) |-> !mem_we)
		else $error("bit store written during a query");

	// probes issued never exceed the probe count of the request
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (issue_cnt_q <= k_q))
		else $error("more probes issued than requested");

	// a probe is only in flight while a request runs
	a_s1_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_RUN))
		else $error("probe in flight outside run");

	// the add counter never goes backwards
	a_cnt_mono: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> (add_cnt_q >= $past(add_cnt_q)))
		else $error("add counter decreased");

endmodule
